[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising aclk edge outside reset.
`define BRLP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Flag any rising aclk edge outside reset at which cond holds.
`define BRLP_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

[hw/rtl/brlp_pkg.sv]
// Shared constants and types of the byte run-length packer.
package brlp_pkg;

    localparam int LIT_DEPTH = 128;
    localparam int LIT_AW    = $clog2(LIT_DEPTH);
    localparam int CNT_W     = 7;
    localparam int WORD_W    = 64;
    localparam int BCNT_W    = 4;

    localparam logic [CNT_W-1:0] MAX_PACKET = 7'd127;
    localparam logic [CNT_W-1:0] RUN_START  = 7'd2;

    localparam logic [1:0] KIND_IDLE = 2'd0;
    localparam logic [1:0] KIND_RUN  = 2'd1;
    localparam logic [1:0] KIND_LIT  = 2'd2;

    localparam logic [7:0] HDR_B0   = 8'h50;
    localparam logic [7:0] HDR_B1   = 8'h47;
    localparam logic [7:0] HDR_B2   = 8'h01;
    localparam logic [7:0] RUN_FLAG = 8'h80;

    typedef struct packed {
        logic              en;
        logic [LIT_AW-1:0] addr;
        logic [7:0]        data;
    } lit_wr_t;

endpackage

[hw/rtl/brlp_lit_store.sv]
// Literal byte store: one write port, one registered read port.
module brlp_lit_store import brlp_pkg::*; (
    input  logic              aclk,
    input  lit_wr_t           wr,
    input  logic              rd_en,
    input  logic [LIT_AW-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [0:LIT_DEPTH-1];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Hold the read data while the reader stalls.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/byte_run_length_packer.sv]
// Byte run-length packer. Takes one byte per transaction on the s_ channel (s_tlast marks the
// frame's final byte) and returns packed words of up to 8 bytes on the m_ channel. With
// compression on, each frame opens with a 3-byte header word, then run packets (0x80|count,
// value) and literal packets (count, bytes) follow; with it off each byte comes back as a
// 1-byte word. One item is handled at a time by a small sequencer, which takes no new byte
// until the last is through; the header, the start of a run, a run word, a frame end and each
// literal byte take steps of their own (a differing byte that closes a run is then taken
// again), as the literal store is read one byte a cycle while the output can take words and a
// single byte-insert shifter builds the words. A stalled m_ channel holds the sequencer.
`include "assert_macros.svh"

module byte_run_length_packer import brlp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // compress_enable
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic        s_tlast,       // frame_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,       // [63:0] out_bytes, [67:64] byte_count, rest zero
    output logic        m_tlast,       // frame_done
    output logic        m_tuser        // last_of_run
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_HDR       = 4'd1;
    localparam logic [3:0] S_FEED      = 4'd2;
    localparam logic [3:0] S_START_RUN = 4'd3;
    localparam logic [3:0] S_FLUSH     = 4'd4;
    localparam logic [3:0] S_FEND      = 4'd5;
    localparam logic [3:0] S_RUN       = 4'd6;
    localparam logic [3:0] S_LIT       = 4'd7;
    localparam logic [3:0] S_DONE      = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [3:0]        ret_reg, ret_next;
    logic              cfg_reg;
    logic [7:0]        x_reg, x_next;
    logic              last_reg, last_next;
    logic [1:0]        kind_reg, kind_next;
    logic [CNT_W-1:0]  lc_reg, lc_next;
    logic [7:0]        rv_reg, rv_next;
    logic [CNT_W-1:0]  rc_reg, rc_next;
    logic [7:0]        la_reg, la_next;
    logic              lv_reg, lv_next;
    logic              hp_reg, hp_next;
    logic [7:0]        pos_reg, pos_next;
    logic [2:0]        wcnt_reg, wcnt_next;
    logic [WORD_W-1:0] wbuf_reg, wbuf_next;

    logic              pend_valid_reg, pend_valid_next;
    logic [WORD_W-1:0] pend_data_reg, pend_data_next;
    logic [BCNT_W-1:0] pend_cnt_reg, pend_cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_data_reg, m_data_next;
    logic [BCNT_W-1:0] m_cnt_reg, m_cnt_next;
    logic              m_fd_reg, m_fd_next;
    logic              m_lor_reg, m_lor_next;

    lit_wr_t           lit_wr;
    logic              rd_en;
    logic [7:0]        rd_data;

    logic              prod_req;
    logic [WORD_W-1:0] prod_data;
    logic [BCNT_W-1:0] prod_cnt;
    logic              prod_fire;
    logic              done_push;
    logic              out_free;
    logic              can_produce;

    logic [7:0]        lit_byte;
    logic [WORD_W-1:0] wbuf_ins;
    logic              word_full;
    logic              pkt_end;
    logic              lit_emit;

    brlp_lit_store u_lit_store (
        .aclk    (aclk),
        .wr      (lit_wr),
        .rd_en   (rd_en),
        .rd_addr (pos_reg[LIT_AW-1:0]),
        .rd_data (rd_data)
    );

    assign s_tready    = (state_reg == S_IDLE);
    assign out_free    = !m_valid_reg || m_tready;
    assign can_produce = !pend_valid_reg || out_free;
    assign prod_fire   = prod_req && can_produce;

    // Byte-insert shifter: the one unit that assembles literal words.
    assign lit_byte  = (pos_reg == 8'd0) ? {1'b0, lc_reg} : rd_data;
    assign wbuf_ins  = wbuf_reg | ({{(WORD_W-8){1'b0}}, lit_byte} << {wcnt_reg, 3'b000});
    assign word_full = (wcnt_reg == 3'd7);
    assign pkt_end   = (pos_reg == {1'b0, lc_reg});
    assign lit_emit  = word_full || pkt_end;

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        x_next     = x_reg;
        last_next  = last_reg;
        kind_next  = kind_reg;
        lc_next    = lc_reg;
        rv_next    = rv_reg;
        rc_next    = rc_reg;
        la_next    = la_reg;
        lv_next    = lv_reg;
        hp_next    = hp_reg;
        pos_next   = pos_reg;
        wcnt_next  = wcnt_reg;
        wbuf_next  = wbuf_reg;
        lit_wr     = '0;
        rd_en      = 1'b0;
        prod_req   = 1'b0;
        prod_data  = '0;
        prod_cnt   = '0;
        done_push  = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    x_next    = s_tdata;
                    last_next = s_tlast;
                    if (!cfg_reg) begin
                        // Pass the byte through and drop any open packet.
                        prod_req   = 1'b1;
                        prod_data  = {{(WORD_W-8){1'b0}}, s_tdata};
                        prod_cnt   = 4'd1;
                        kind_next  = KIND_IDLE;
                        lv_next    = 1'b0;
                        lc_next    = '0;
                        rc_next    = '0;
                        hp_next    = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        state_next = hp_reg ? S_HDR : S_FEED;
                    end
                end
            end
            S_HDR: begin
                prod_req  = 1'b1;
                prod_data = {{(WORD_W-24){1'b0}}, HDR_B2, HDR_B1, HDR_B0};
                prod_cnt  = 4'd3;
                if (can_produce) begin
                    hp_next    = 1'b0;
                    state_next = S_FEED;
                end
            end
            S_FEED: begin
                if (kind_reg == KIND_RUN) begin
                    if (x_reg == rv_reg && rc_reg < MAX_PACKET) begin
                        rc_next = rc_reg + 7'd1;
                        if (rc_reg + 7'd1 >= MAX_PACKET) begin
                            ret_next   = S_FLUSH;
                            state_next = S_RUN;
                        end else begin
                            state_next = S_FLUSH;
                        end
                    end else begin
                        // Close the run, then come back with no packet open.
                        ret_next   = S_FEED;
                        state_next = S_RUN;
                    end
                end else if (kind_reg == KIND_LIT) begin
                    if (la_reg != x_reg) begin
                        lit_wr.en   = 1'b1;
                        lit_wr.addr = lc_reg[LIT_AW-1:0];
                        lit_wr.data = la_reg;
                        lc_next     = lc_reg + 7'd1;
                        la_next     = x_reg;
                        lv_next     = 1'b1;
                        if (lc_reg + 7'd1 >= MAX_PACKET) begin
                            ret_next   = S_FLUSH;
                            state_next = S_LIT;
                        end else begin
                            state_next = S_FLUSH;
                        end
                    end else begin
                        ret_next   = S_START_RUN;
                        state_next = S_LIT;
                    end
                end else begin
                    if (!lv_reg) begin
                        la_next    = x_reg;
                        lv_next    = 1'b1;
                        state_next = S_FLUSH;
                    end else if (la_reg == x_reg) begin
                        state_next = S_START_RUN;
                    end else begin
                        lit_wr.en   = 1'b1;
                        lit_wr.addr = '0;
                        lit_wr.data = la_reg;
                        lc_next     = 7'd1;
                        kind_next   = KIND_LIT;
                        la_next     = x_reg;
                        lv_next     = 1'b1;
                        state_next  = S_FLUSH;
                    end
                end
            end
            S_START_RUN: begin
                kind_next = KIND_RUN;
                rv_next   = la_reg;
                rc_next   = RUN_START;
                lv_next   = 1'b0;
                if (RUN_START >= MAX_PACKET) begin
                    ret_next   = S_FLUSH;
                    state_next = S_RUN;
                end else begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!last_reg) begin
                    state_next = S_DONE;
                end else if (kind_reg == KIND_RUN) begin
                    ret_next   = S_FEND;
                    state_next = S_RUN;
                end else if (kind_reg == KIND_LIT) begin
                    lit_wr.en   = 1'b1;
                    lit_wr.addr = lc_reg[LIT_AW-1:0];
                    lit_wr.data = la_reg;
                    lc_next     = lc_reg + 7'd1;
                    ret_next    = S_FEND;
                    state_next  = S_LIT;
                end else if (lv_reg) begin
                    lit_wr.en   = 1'b1;
                    lit_wr.addr = '0;
                    lit_wr.data = la_reg;
                    lc_next     = 7'd1;
                    kind_next   = KIND_LIT;
                    ret_next    = S_FEND;
                    state_next  = S_LIT;
                end else begin
                    state_next = S_FEND;
                end
            end
            S_FEND: begin
                kind_next  = KIND_IDLE;
                lv_next    = 1'b0;
                hp_next    = 1'b1;
                state_next = S_DONE;
            end
            S_RUN: begin
                prod_req  = 1'b1;
                prod_data = {{(WORD_W-16){1'b0}}, rv_reg, RUN_FLAG | {1'b0, rc_reg}};
                prod_cnt  = 4'd2;
                if (can_produce) begin
                    kind_next  = KIND_IDLE;
                    rc_next    = '0;
                    state_next = ret_reg;
                end
            end
            S_LIT: begin
                if (lit_emit) begin
                    prod_req  = 1'b1;
                    prod_data = wbuf_ins;
                    prod_cnt  = {1'b0, wcnt_reg} + 4'd1;
                end
                if (!lit_emit || can_produce) begin
                    rd_en    = 1'b1;
                    pos_next = pos_reg + 8'd1;
                    if (lit_emit) begin
                        wbuf_next = '0;
                        wcnt_next = '0;
                    end else begin
                        wbuf_next = wbuf_ins;
                        wcnt_next = wcnt_reg + 3'd1;
                    end
                    if (pkt_end) begin
                        kind_next  = KIND_IDLE;
                        lc_next    = '0;
                        pos_next   = '0;
                        state_next = ret_reg;
                    end
                end
            end
            S_DONE: begin
                // Release the held word as the item's final transaction.
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    done_push  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A word waits in the pending slot until the next word or the item's end shows
    // whether it is the last one.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        pend_cnt_next   = pend_cnt_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_cnt_next      = m_cnt_reg;
        m_fd_next       = m_fd_reg;
        m_lor_next      = m_lor_reg;

        if ((prod_fire && pend_valid_reg) || done_push) begin
            m_valid_next = 1'b1;
            m_data_next  = pend_data_reg;
            m_cnt_next   = pend_cnt_reg;
            m_fd_next    = done_push && last_reg;
            m_lor_next   = done_push;
        end
        if (prod_fire) begin
            pend_valid_next = 1'b1;
            pend_data_next  = prod_data;
            pend_cnt_next   = prod_cnt;
        end else if (done_push) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cfg_reg        <= 1'b1;
            kind_reg       <= KIND_IDLE;
            lc_reg         <= '0;
            rv_reg         <= '0;
            rc_reg         <= '0;
            la_reg         <= '0;
            lv_reg         <= 1'b0;
            hp_reg         <= 1'b1;
            pos_reg        <= '0;
            wcnt_reg       <= '0;
            wbuf_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            kind_reg       <= kind_next;
            lc_reg         <= lc_next;
            rv_reg         <= rv_next;
            rc_reg         <= rc_next;
            la_reg         <= la_next;
            lv_reg         <= lv_next;
            hp_reg         <= hp_next;
            pos_reg        <= pos_next;
            wcnt_reg       <= wcnt_next;
            wbuf_reg       <= wbuf_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg       <= ret_next;
        x_reg         <= x_next;
        last_reg      <= last_next;
        pend_data_reg <= pend_data_next;
        pend_cnt_reg  <= pend_cnt_next;
        m_data_reg    <= m_data_next;
        m_cnt_reg     <= m_cnt_next;
        m_fd_reg      <= m_fd_next;
        m_lor_reg     <= m_lor_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_cnt_reg, m_data_reg};
    assign m_tlast  = m_fd_reg;
    assign m_tuser  = m_lor_reg;

    `BRLP_NEVER(a_pend_empty_on_accept,
        s_tready && pend_valid_reg,
        "word left pending at accept")
    `BRLP_NEVER(a_lit_not_empty,
        (state_reg == S_IDLE) && (kind_reg == KIND_LIT) && (lc_reg == '0),
        "open literal has no bytes")
    `BRLP_NEVER(a_run_min_len,
        (state_reg == S_IDLE) && (kind_reg == KIND_RUN) && (rc_reg < RUN_START),
        "open run shorter than two")
    `BRLP_ASSERT(a_done_returns,
        (state_reg == S_DONE) && !pend_valid_reg |=> s_tready,
        "item end did not return to accept")

endmodule

[dv/tb_top.sv]
// Testbench for the byte run-length packer: predicts packed output words and checks them.
module tb_top import brlp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 300;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_REPORTS   = 200;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        frame_done;
        logic        last_of_run;
    } out_word_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } in_byte_t;

    typedef enum int {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_PERIODIC} stall_mode_e;

    class rle_scoreboard;
        logic [7:0] lit_store [LIT_DEPTH];
        logic [6:0] lit_count;
        logic [7:0] run_value;
        logic [6:0] run_count;
        logic [1:0] kind;
        logic [7:0] look_byte;
        logic       look_valid;
        logic       header_due;
        logic       compress_on;
        out_word_t  step_words [$];
        out_word_t  words_due [$];
        int         errors;
        int         words_seen;
        int         bytes_in;
        int         frames_in;

        function new();
            foreach (lit_store[i]) lit_store[i] = 8'h00;
            lit_count   = '0;
            run_value   = '0;
            run_count   = '0;
            kind        = KIND_IDLE;
            look_byte   = '0;
            look_valid  = 1'b0;
            header_due  = 1'b1;
            compress_on = 1'b1;
            errors      = 0;
            words_seen  = 0;
            bytes_in    = 0;
            frames_in   = 0;
        endfunction

        function void push_word(logic [63:0] w, int n);
            out_word_t x;
            x.bytes       = w;
            x.count       = n[3:0];
            x.frame_done  = 1'b0;
            x.last_of_run = 1'b0;
            step_words.push_back(x);
        endfunction

        function void close_run();
            push_word({48'h0, run_value, RUN_FLAG | {1'b0, run_count}}, 2);
            kind      = KIND_IDLE;
            run_count = '0;
        endfunction

        // Emit count byte plus stored bytes, cut into words of eight.
        function void close_literal();
            logic [63:0] w;
            int total;
            int pos;
            int n;
            total = lit_count + 1;
            for (pos = 0; pos < total; pos += n) begin
                n = (total - pos > 8) ? 8 : total - pos;
                w = '0;
                for (int k = 0; k < n; k++) begin
                    w[8*k +: 8] = (pos + k == 0) ? {1'b0, lit_count} : lit_store[pos + k - 1];
                end
                push_word(w, n);
            end
            kind      = KIND_IDLE;
            lit_count = '0;
        endfunction

        function void append_literal(logic [7:0] c);
            lit_store[lit_count] = c;
            lit_count = lit_count + 7'd1;
            kind = KIND_LIT;
            if (lit_count >= MAX_PACKET) close_literal();
        endfunction

        function void open_run(logic [7:0] c);
            kind       = KIND_RUN;
            run_value  = c;
            run_count  = RUN_START;
            look_valid = 1'b0;
            if (run_count >= MAX_PACKET) close_run();
        endfunction

        function void take_byte(logic [7:0] x);
            if (kind == KIND_RUN) begin
                if (x == run_value && run_count < MAX_PACKET) begin
                    run_count = run_count + 7'd1;
                    if (run_count >= MAX_PACKET) close_run();
                    return;
                end
                close_run();
            end
            if (kind == KIND_LIT) begin
                if (look_byte != x) begin
                    append_literal(look_byte);
                    look_byte  = x;
                    look_valid = 1'b1;
                end else begin
                    close_literal();
                    open_run(x);
                end
                return;
            end
            if (!look_valid) begin
                look_byte  = x;
                look_valid = 1'b1;
                return;
            end
            if (look_byte == x) begin
                open_run(x);
            end else begin
                lit_count = '0;
                append_literal(look_byte);
                look_byte  = x;
                look_valid = 1'b1;
            end
        endfunction

        // The byte past the frame end never matches, so the held byte closes as a literal.
        function void end_frame();
            if (kind == KIND_RUN) begin
                close_run();
            end else if (kind == KIND_LIT) begin
                append_literal(look_byte);
                if (kind == KIND_LIT) close_literal();
            end else if (look_valid) begin
                lit_count = '0;
                append_literal(look_byte);
                if (kind == KIND_LIT) close_literal();
            end
            kind       = KIND_IDLE;
            look_valid = 1'b0;
            header_due = 1'b1;
        endfunction

        function void accept_byte(logic [7:0] b, logic last);
            out_word_t tail;
            bytes_in++;
            if (last) frames_in++;
            step_words.delete();
            if (!compress_on) begin
                push_word({56'h0, b}, 1);
                kind       = KIND_IDLE;
                look_valid = 1'b0;
                lit_count  = '0;
                run_count  = '0;
                header_due = 1'b1;
            end else begin
                if (header_due) begin
                    push_word({40'h0, HDR_B2, HDR_B1, HDR_B0}, 3);
                    header_due = 1'b0;
                end
                take_byte(b);
                if (last) end_frame();
            end
            if (step_words.size() > 0) begin
                tail = step_words.pop_back();
                tail.last_of_run = 1'b1;
                tail.frame_done  = last;
                step_words.push_back(tail);
            end
            foreach (step_words[i]) words_due.push_back(step_words[i]);
        endfunction

        function void report(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s expected %h actual %h", $time, what, want, got);
        endfunction

        function void check_word(logic [63:0] bytes, logic [3:0] count, logic done, logic lor);
            out_word_t want;
            if (words_due.size() == 0) begin
                report("unexpected word, out_bytes", 64'h0, bytes);
                return;
            end
            want = words_due.pop_front();
            words_seen++;
            if (bytes !== want.bytes) report("out_bytes", want.bytes, bytes);
            if (count !== want.count) report("byte_count", want.count, count);
            if (done !== want.frame_done) report("frame_done", want.frame_done, done);
            if (lor !== want.last_of_run) report("last_of_run", want.last_of_run, lor);
        endfunction

        function int pending();
            return words_due.size();
        endfunction
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    rle_scoreboard sb = new();
    in_byte_t      stim_q [$];
    int            burst_left    = 0;
    int            hold_requests = 0;
    int            holds_done    = 0;
    int            mode_changes  = 0;

    always #6 aclk = ~aclk;

    byte_run_length_packer u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    initial begin
        #5_000_000;
        $display("Timeout: run did not complete");
        $display("Mismatches found");
        $finish;
    end

    // Check each output transaction, then pick the next m_tready value.
    initial begin : result_sink
        int          hold_left;
        int          mode_left;
        stall_mode_e mode;
        hold_left = 0;
        mode_left = 0;
        mode      = READY_ALWAYS;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_word(m_tdata[63:0], m_tdata[67:64], m_tlast, m_tuser);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = stall_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
                    READY_MOSTLY: m_tready <= ($urandom_range(0, 4) != 0);
                    default:      m_tready <= ((mode_left % 8) < 5);
                endcase
            end
        end
    end

    // Call at a rising edge; returns at the edge that accepts the transaction.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.accept_byte(b, last);
        burst_left--;
    endtask

    task automatic send_queued();
        in_byte_t it;
        while (stim_q.size() > 0) begin
            it = stim_q.pop_front();
            send_byte(it.value, it.last);
        end
    endtask

    // Hold the sender until every expected word is back, then let the block go quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic on);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.compress_on = on;
        mode_changes++;
    endtask

    function automatic void push_item(logic [7:0] v, logic last);
        stim_q.push_back({v, last});
    endfunction

    function automatic void add_run(logic [7:0] v, int len);
        for (int i = 0; i < len; i++) push_item(v, 1'b0);
    endfunction

    // Adjacent bytes always differ.
    function automatic logic [7:0] add_literal(logic [7:0] prev, int len);
        logic [7:0] v;
        v = prev;
        for (int i = 0; i < len; i++) begin
            v = v + 8'($urandom_range(1, 255));
            push_item(v, 1'b0);
        end
        return v;
    endfunction

    function automatic void mark_frame_end();
        in_byte_t tail;
        tail = stim_q.pop_back();
        tail.last = 1'b1;
        stim_q.push_back(tail);
    endfunction

    function automatic void add_random_frame(logic closed);
        int         segs;
        int         sel;
        int         len;
        logic [7:0] prev;
        logic [7:0] v;
        segs = $urandom_range(1, 6);
        prev = 8'($urandom);
        for (int s = 0; s < segs; s++) begin
            sel = $urandom_range(2, 59);
            if (sel < 28) begin
                v = ($urandom_range(0, 3) == 0) ? prev : 8'($urandom);
                add_run(v, $urandom_range(2, 6));
                prev = v;
            end else if (sel < 52) begin
                prev = add_literal(prev, $urandom_range(1, 8));
            end else begin
                // loose pairs and singles, each byte repeating the last one or changing it
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    v = ($urandom_range(0, 1) == 1) ? prev : prev ^ 8'($urandom_range(1, 255));
                    push_item(v, 1'b0);
                    prev = v;
                end
            end
        end
        if (closed) mark_frame_end();
    endfunction

    task automatic send_random_frames(input int count);
        int stop_at;
        stop_at = sb.bytes_in + count;
        while (sb.bytes_in < stop_at) begin
            add_random_frame(1'b1);
            send_queued();
        end
    endtask

    task automatic send_raw_bytes(input int count);
        for (int i = 0; i < count; i++)
            send_byte(8'($urandom), $urandom_range(0, 3) == 0);
    endtask

    initial begin : stimulus
        logic [7:0] v;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // single byte frame, pair at frame end, literal into run, 8-byte literal, two runs
        push_item(8'h00, 1'b1);
        push_item(8'hFF, 1'b0); push_item(8'hFF, 1'b1);
        push_item(8'h12, 1'b0); push_item(8'h34, 1'b0); push_item(8'h34, 1'b0);
        push_item(8'h34, 1'b0); push_item(8'h56, 1'b1);
        push_item(8'h80, 1'b0); push_item(8'h7F, 1'b0); push_item(8'h01, 1'b0);
        push_item(8'hAA, 1'b0); push_item(8'h55, 1'b0); push_item(8'hFE, 1'b0);
        push_item(8'h01, 1'b0); push_item(8'hA5, 1'b1);
        push_item(8'h5A, 1'b0); push_item(8'h5A, 1'b0); push_item(8'h5A, 1'b0);
        push_item(8'hC3, 1'b0); push_item(8'hC3, 1'b1);
        send_queued();

        // run past the cap, then a literal past the cap
        add_run(8'hEE, 129);
        v = 8'h01;
        for (int i = 0; i < 130; i++) begin
            push_item(v, 1'b0);
            v = v + 8'd3;
        end
        mark_frame_end();
        send_queued();
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_requests++;
        send_random_frames(8);
        drain();

        write_mode(1'b0);
        send_raw_bytes(8);
        drain();

        write_mode(1'b1);
        send_random_frames(8);
        // leave a packet open, then switch to raw mid-frame
        push_item(8'h11, 1'b0); push_item(8'h22, 1'b0);
        push_item(8'h22, 1'b0); push_item(8'h33, 1'b0);
        send_queued();
        drain();

        write_mode(1'b0);
        send_raw_bytes(4);
        drain();

        write_mode(1'b1);
        add_random_frame(1'b0);
        send_queued();
        send_random_frames(8);
        drain();

        $display("Run covered %0d input bytes in %0d frames and %0d mode writes,",
                 sb.bytes_in, sb.frames_in, mode_changes);
        $display("with %0d output words checked across compressed and raw modes.",
                 sb.words_seen);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/brlp_pkg.sv
hw/rtl/brlp_lit_store.sv
hw/rtl/byte_run_length_packer.sv
dv/tb_top.sv
